/* rtl/core/acle_pkg.sv */
`timescale 1ns / 1ps

package acle_pkg;

    localparam int NODES_DEFAULT = 16;
    localparam int DATA_W        = 32;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DUMP   = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

/* rtl/core/acle_store.sv */
`timescale 1ns / 1ps

module acle_store #(
    parameter int NODES  = acle_pkg::NODES_DEFAULT,
    parameter int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1,
    parameter int LINK_W = $clog2(NODES + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [IDX_W-1:0]           rd_addr,
    output logic [LINK_W-1:0]          rd_link,
    output logic [acle_pkg::DATA_W-1:0] rd_data,
    input  logic                       link_we,
    input  logic [IDX_W-1:0]           link_waddr,
    input  logic [LINK_W-1:0]          link_wdata,
    input  logic                       data_we,
    input  logic [IDX_W-1:0]           data_waddr,
    input  logic [acle_pkg::DATA_W-1:0] data_wdata
);
    import acle_pkg::*;

    logic [LINK_W-1:0] link_mem [NODES];
    logic [DATA_W-1:0] data_mem [NODES];
    logic [NODES-1:0]  link_valid_reg;
    logic [LINK_W-1:0] link_q_reg;
    logic              link_valid_q_reg;
    logic [IDX_W-1:0]  addr_q_reg;
    logic [DATA_W-1:0] data_q_reg;

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_q_reg <= link_mem[rd_addr];
        addr_q_reg <= rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_waddr] <= data_wdata;
        end
        data_q_reg <= data_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_valid_reg   <= '0;
            link_valid_q_reg <= 1'b0;
        end
        else
        begin
            if (link_we)
            begin
                link_valid_reg[link_waddr] <= 1'b1;
            end
            link_valid_q_reg <= link_valid_reg[rd_addr];
        end
    end

    // unwritten link reads as its reset value, entry i links to i+1
    assign rd_link = link_valid_q_reg ? link_q_reg
                                      : LINK_W'(addr_q_reg) + LINK_W'(1);
    assign rd_data = data_q_reg;

endmodule

/* rtl/core/array_circular_list_engine_top.sv */
`timescale 1ns / 1ps

// Circular linked list engine over a node store with a free chain.
// Input channel s_*: s_tuser[0] is the operation (0 insert, 1 dump),
// s_tdata[31:0] the signed value to insert. Output channel m_*: m_tuser[0]
// is the reply kind (0 insert acknowledge, 1 list entry), m_tuser[1] the
// status (1 list full, insert refused), m_tdata[31:0] the entry value and
// m_tlast marks the final transfer caused by one input item.
// An insert into a non-empty list goes through accept, free chain read,
// link reads to find the tail, relink and acknowledge; into an empty list
// it links the new node to itself at the free chain read and skips the walk;
// a refused insert goes from accept to acknowledge. A dump of L entries
// gives L transfers; an empty list gives none. All walks use the single
// registered read port of the node store, one link per cycle unless the output stalls.
// s_tready is high only while no item is in work; one item is in work at a
// time. The output register holds a finished result while m_tready is low;
// the sequencer waits on it, and a dump resumes where it stopped.
// After reset the list is empty, every node is on the free chain and the
// block is ready at once; no clearing pass is needed.
module array_circular_list_engine_top #(
    parameter int NODES = acle_pkg::NODES_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [acle_pkg::DATA_W-1:0] s_tdata,  // value
    input  logic                        s_tuser,  // kind
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [acle_pkg::DATA_W-1:0] m_tdata,  // entry_value
    output logic                        m_tlast,
    output logic [1:0]                  m_tuser   // reply_kind, status
);
    import acle_pkg::*;

    localparam int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LINK_W = $clog2(NODES + 1);
    localparam logic [LINK_W-1:0] NODES_LINK = LINK_W'(NODES);
    localparam logic [IDX_W-1:0]  LAST_CNT   = IDX_W'(NODES - 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_INS_FREE = 3'd1;
    localparam logic [2:0] ST_INS_WALK = 3'd2;
    localparam logic [2:0] ST_INS_LINK = 3'd3;
    localparam logic [2:0] ST_ACK      = 3'd4;
    localparam logic [2:0] ST_DUMP     = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic              empty_reg, empty_next;
    logic [IDX_W-1:0]  fresh_reg, fresh_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              status_reg, status_next;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic              out_kind_reg;
    logic              out_status_reg;

    logic              out_load;
    logic [DATA_W-1:0] load_data;
    logic              load_last;
    logic              load_kind;
    logic              load_status;

    logic [IDX_W-1:0]  rd_addr;
    logic [LINK_W-1:0] rd_link;
    logic [DATA_W-1:0] rd_data;
    logic              link_we;
    logic [IDX_W-1:0]  link_waddr;
    logic [LINK_W-1:0] link_wdata;
    logic              data_we;

    logic              accept;
    logic              out_free;
    logic              full;
    logic              stop;
    logic [IDX_W-1:0]  nx_idx;

    acle_store #(
        .NODES  (NODES),
        .IDX_W  (IDX_W),
        .LINK_W (LINK_W)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_addr    (rd_addr),
        .rd_link    (rd_link),
        .rd_data    (rd_data),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .data_we    (data_we),
        .data_waddr (free_head_reg[IDX_W-1:0]),
        .data_wdata (s_tdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign full     = (free_head_reg >= NODES_LINK);
    assign nx_idx   = rd_link[IDX_W-1:0];
    assign stop     = (rd_link == LINK_W'(head_reg)) || (rd_link >= NODES_LINK);

    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        head_next      = head_reg;
        empty_next     = empty_reg;
        fresh_next     = fresh_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        rd_addr        = head_reg;
        link_we        = 1'b0;
        link_waddr     = fresh_reg;
        link_wdata     = LINK_W'(fresh_reg);
        data_we        = 1'b0;
        out_load       = 1'b0;
        load_data      = '0;
        load_last      = 1'b1;
        load_kind      = KIND_INSERT;
        load_status    = status_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tuser == KIND_INSERT)
                begin
                    rd_addr = free_head_reg[IDX_W-1:0];
                end
                if (accept)
                begin
                    if (s_tuser == KIND_INSERT)
                    begin
                        if (full)
                        begin
                            status_next = STATUS_FULL;
                            state_next  = ST_ACK;
                        end
                        else
                        begin
                            data_we    = 1'b1;
                            fresh_next = free_head_reg[IDX_W-1:0];
                            state_next = ST_INS_FREE;
                        end
                    end
                    else if (!empty_reg)
                    begin
                        cur_next   = head_reg;
                        cnt_next   = '0;
                        state_next = ST_DUMP;
                    end
                end
            end
            ST_INS_FREE:
            begin
                free_head_next = (rd_link > NODES_LINK) ? NODES_LINK : rd_link;
                status_next    = STATUS_OK;
                if (empty_reg)
                begin
                    link_we    = 1'b1;
                    head_next  = fresh_reg;
                    empty_next = 1'b0;
                    state_next = ST_ACK;
                end
                else
                begin
                    cur_next   = head_reg;
                    cnt_next   = '0;
                    state_next = ST_INS_WALK;
                end
            end
            ST_INS_WALK:
            begin
                if (stop || cnt_reg == LAST_CNT)
                begin
                    link_we    = 1'b1;
                    link_waddr = stop ? cur_reg : nx_idx;
                    state_next = ST_INS_LINK;
                end
                else
                begin
                    rd_addr  = nx_idx;
                    cur_next = nx_idx;
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_INS_LINK:
            begin
                link_we    = 1'b1;
                link_wdata = LINK_W'(head_reg);
                head_next  = fresh_reg;
                empty_next = 1'b0;
                state_next = ST_ACK;
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                rd_addr = cur_reg;
                if (out_free)
                begin
                    out_load    = 1'b1;
                    load_data   = rd_data;
                    load_kind   = KIND_DUMP;
                    load_status = STATUS_OK;
                    load_last   = stop || (cnt_reg == LAST_CNT);
                    if (load_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_addr  = nx_idx;
                        cur_next = nx_idx;
                        cnt_next = cnt_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_head_reg <= '0;
            head_reg      <= '0;
            empty_reg     <= 1'b1;
            status_reg    <= STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            head_reg      <= head_next;
            empty_reg     <= empty_next;
            status_reg    <= status_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fresh_reg <= fresh_next;
        cur_reg   <= cur_next;
        cnt_reg   <= cnt_next;
        if (out_load)
        begin
            out_data_reg   <= load_data;
            out_last_reg   <= load_last;
            out_kind_reg   <= load_kind;
            out_status_reg <= load_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_status_reg, out_kind_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= NODES_LINK)
        else $error("free chain head out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == KIND_INSERT |-> m_tlast && m_tdata == '0)
        else $error("insert acknowledge not single and zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == KIND_DUMP |-> m_tuser[1] == STATUS_OK)
        else $error("dump entry with nonzero status");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INS_LINK |=> !empty_reg && head_reg == $past(fresh_reg))
        else $error("insert did not set new head");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ACK && status_reg == STATUS_FULL |-> free_head_reg == NODES_LINK)
        else $error("insert refused while a node is free");

endmodule
